// ----- rtl/core/vna_pkg.sv -----
// shared types and constants of the vertex normal accumulator
package vna_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TRI   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_ZERO  = 2'd2
   } status_type;

   typedef struct packed {
      action_type         action;
      logic        [15:0] index_a;
      logic        [15:0] index_b;
      logic        [15:0] index_c;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } rsp_type;

   localparam int UNIT  = 16384;
   localparam int SQ_W  = 62;  // sum of three squares
   localparam int LEN_W = 31;  // vector length
   localparam int QUO_W = 17;  // quotient bits of one component
   localparam int NUM_W = 46;  // dividend bits
   localparam int DEN_W = 32;  // divisor bits

   typedef enum logic {
      OP_SQRT = 1'b0,
      OP_DIV  = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ----- rtl/core/vna_root_div.sv -----
// iterative square root and divide unit, one subtract-compare step per cycle
module vna_root_div (
   input  logic                         clock,
   input  logic                         reset,
   input  vna_pkg::unit_ctrl_type       ctrl,
   input  logic [vna_pkg::SQ_W-1:0]     rad,
   input  logic [vna_pkg::NUM_W-1:0]    num,
   input  logic [vna_pkg::DEN_W-1:0]    den,
   output vna_pkg::unit_stat_type       stat,
   output logic [vna_pkg::LEN_W-1:0]    root,
   output logic [vna_pkg::QUO_W-1:0]    quot
);
   import vna_pkg::*;

   localparam logic [5:0] SQRT_LAST = 6'd31;
   localparam logic [5:0] DIV_LAST  = 6'(QUO_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   unit_op_type       op_ff, op_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [63:0]       work_ff, work_in;
   logic [63:0]       res_ff, res_in;
   logic [63:0]       bit_ff, bit_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [63:0]       a_sel, b_sel;
   logic [64:0]       diff;
   logic              ge;

   // shared subtractor and step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      if (op_ff == OP_SQRT) begin
         a_sel = work_ff;
         b_sel = res_ff + bit_ff;
      end else begin
         a_sel = {31'd0, work_ff[31:0], low_ff[QUO_W-1]};
         b_sel = 64'(den_ff);
      end
      diff = {1'b0, a_sel} - {1'b0, b_sel};
      ge   = !diff[64];
      if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (op_ff == OP_SQRT) begin
            if (ge) begin
               work_in = diff[63:0];
               res_in  = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == SQRT_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            work_in = ge ? diff[63:0] : a_sel;
            res_in  = {res_ff[62:0], ge};
            low_in  = low_ff << 1;
            if (cnt_ff == DIV_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end else if (ctrl.start) begin
         busy_in = 1'b1;
         op_in   = ctrl.op;
         cnt_in  = 6'd0;
         res_in  = 64'd0;
         bit_in  = 64'h4000_0000_0000_0000;
         den_in  = den;
         if (ctrl.op == OP_SQRT) begin
            work_in = 64'(rad);
         end else begin
            work_in = 64'(num[NUM_W-1:QUO_W]);
            low_in  = num[QUO_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_SQRT;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      low_ff  <= low_in;
      den_ff  <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = res_ff[LEN_W-1:0];
   assign quot      = res_ff[QUO_W-1:0];

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a run");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (ctrl.start && !busy_ff) |=> busy_ff) else $error("start not taken");
`endif

endmodule

// ----- rtl/core/vertex_normal_accumulator_core.sv -----
// vertex normal accumulator top level: stores, sequencer and shared multiplier
//
// One command is taken when start is high and busy is low; every command gives
// exactly one result, shown for one cycle with rsp_strobe. Write vertex and any
// out-of-range command answer in the next cycle and leave busy low. Clear
// answers at once, then sweeps the accumulators one entry a cycle; the same
// sweep runs after reset before the first command. Add triangle reads the
// three vertices, forms six products through the one registered 31x31
// multiplier and does three read-modify-writes of the accumulator memory.
// Read normal makes up to 18 one-bit shifts to bring the vector under 2^30,
// forms three squares through the multiplier, then the iterative unit runs a
// 32-step square root and three 17-step divisions.
module vertex_normal_accumulator_core #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vna_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output vna_pkg::rsp_type  rsp_item
);
   import vna_pkg::*;

   localparam int          AW    = $clog2(MAX_VERTICES);
   localparam logic [16:0] MAX_V = 17'(MAX_VERTICES);
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_CLEAR     = 13'b0000000000010,
      ST_VRD       = 13'b0000000000100,
      ST_DIFF      = 13'b0000000001000,
      ST_CROSS     = 13'b0000000010000,
      ST_ACC_RD    = 13'b0000000100000,
      ST_ACC_WR    = 13'b0000001000000,
      ST_NRM_RD    = 13'b0000010000000,
      ST_NRM_LD    = 13'b0000100000000,
      ST_NRM_SHIFT = 13'b0001000000000,
      ST_NRM_SQ    = 13'b0010000000000,
      ST_NRM_SQRT  = 13'b0100000000000,
      ST_NRM_DIV   = 13'b1000000000000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [2:0]         k_ff, k_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [47:0]        p_ff [3], p_in [3];
   logic signed [16:0] d_ff [6], d_in [6];
   logic signed [34:0] c_ff [3], c_in [3];
   logic [47:0]        r_ff [3], r_in [3];
   logic [2:0]         sgn_ff, sgn_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic signed [15:0] nrm_ff [3], nrm_in [3];
   logic               launched_ff, launched_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;
   logic signed [61:0] prod_ff;

   logic [47:0]        vtx_mem [MAX_VERTICES];
   logic [47:0]        vtx_q_ff;
   logic [143:0]       acc_mem [MAX_VERTICES];
   logic [143:0]       acc_q_ff;

   logic               accept;
   logic               a_ok, b_ok, c_ok;
   logic [15:0]        sel_idx;
   logic [AW-1:0]      cur_idx;
   logic               vtx_we;
   logic               acc_we;
   logic [AW-1:0]      acc_wa;
   logic [143:0]       acc_wd;
   logic signed [30:0] mul_a, mul_b;
   unit_ctrl_type      u_ctrl;
   unit_stat_type      u_stat;
   logic [NUM_W-1:0]   u_num;
   logic [DEN_W-1:0]   u_den;
   logic [LEN_W-1:0]   u_root;
   logic [QUO_W-1:0]   u_quot;
   logic [QUO_W-1:0]   q_clip;
   logic signed [15:0] q_signed;
   logic [47:0]        ax, ay, az;

   function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                  input logic signed [34:0] b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s[48] != s[47]) begin
         return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      return s[47:0];
   endfunction

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // range checks on the incoming command
   assign a_ok = {1'b0, req_item.index_a} < MAX_V;
   assign b_ok = {1'b0, req_item.index_b} < MAX_V;
   assign c_ok = {1'b0, req_item.index_c} < MAX_V;

   // corner address for vertex and accumulator reads
   always_comb begin
      case (k_ff[1:0])
         2'd1:    sel_idx = req_ff.index_b;
         2'd2:    sel_idx = req_ff.index_c;
         default: sel_idx = req_ff.index_a;
      endcase
   end
   assign cur_idx = sel_idx[AW-1:0];

   // vertex store
   assign vtx_we = accept && (req_item.action == ACT_WRITE) && a_ok;
   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[req_item.index_a[AW-1:0]] <=
            {req_item.coord_z, req_item.coord_y, req_item.coord_x};
      end
      vtx_q_ff <= vtx_mem[cur_idx];
   end

   // accumulator store, x in the low word
   assign ax = acc_q_ff[47:0];
   assign ay = acc_q_ff[95:48];
   assign az = acc_q_ff[143:96];

   always_comb begin
      acc_we = 1'b0;
      acc_wa = cur_idx;
      acc_wd = {sat_add(az, c_ff[2]), sat_add(ay, c_ff[1]), sat_add(ax, c_ff[0])};
      if (state_ff == ST_CLEAR) begin
         acc_we = 1'b1;
         acc_wa = clr_ff;
         acc_wd = '0;
      end else if (state_ff == ST_ACC_WR) begin
         acc_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      acc_q_ff <= acc_mem[cur_idx];
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_NRM_SQ) begin
         case (k_ff)
            3'd0: begin
               mul_a = {1'b0, r_ff[0][29:0]};
               mul_b = {1'b0, r_ff[0][29:0]};
            end
            3'd1: begin
               mul_a = {1'b0, r_ff[1][29:0]};
               mul_b = {1'b0, r_ff[1][29:0]};
            end
            default: begin
               mul_a = {1'b0, r_ff[2][29:0]};
               mul_b = {1'b0, r_ff[2][29:0]};
            end
         endcase
      end else begin
         case (k_ff)
            3'd0: begin
               mul_a = 31'(d_ff[1]);
               mul_b = 31'(d_ff[5]);
            end
            3'd1: begin
               mul_a = 31'(d_ff[2]);
               mul_b = 31'(d_ff[4]);
            end
            3'd2: begin
               mul_a = 31'(d_ff[2]);
               mul_b = 31'(d_ff[3]);
            end
            3'd3: begin
               mul_a = 31'(d_ff[0]);
               mul_b = 31'(d_ff[5]);
            end
            3'd4: begin
               mul_a = 31'(d_ff[0]);
               mul_b = 31'(d_ff[4]);
            end
            default: begin
               mul_a = 31'(d_ff[1]);
               mul_b = 31'(d_ff[3]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // iterative root and divide unit
   assign u_ctrl.start = ((state_ff == ST_NRM_SQRT) || (state_ff == ST_NRM_DIV))
                         && !launched_ff;
   assign u_ctrl.op    = (state_ff == ST_NRM_DIV) ? OP_DIV : OP_SQRT;
   assign u_den        = {len_ff, 1'b0};
   always_comb begin
      case (k_ff[1:0])
         2'd1:    u_num = {r_ff[1][29:0], 15'd0} + NUM_W'(len_ff);
         2'd2:    u_num = {r_ff[2][29:0], 15'd0} + NUM_W'(len_ff);
         default: u_num = {r_ff[0][29:0], 15'd0} + NUM_W'(len_ff);
      endcase
   end

   vna_root_div u_root_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (u_ctrl),
      .rad   (sq_ff),
      .num   (u_num),
      .den   (u_den),
      .stat  (u_stat),
      .root  (u_root),
      .quot  (u_quot)
   );

   // limit and sign one normal component
   assign q_clip   = (u_quot > QUO_W'(UNIT)) ? QUO_W'(UNIT) : u_quot;
   assign q_signed = sgn_ff[k_ff[1:0]] ? -16'(q_clip) : 16'(q_clip);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      k_in          = k_ff;
      clr_in        = clr_ff;
      p_in          = p_ff;
      d_in          = d_ff;
      c_in          = c_ff;
      r_in          = r_ff;
      sgn_in        = sgn_ff;
      sq_in         = sq_ff;
      len_in        = len_ff;
      nrm_in        = nrm_ff;
      launched_in   = launched_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in        = req_item;
               k_in          = 3'd0;
               rsp_in        = '0;
               rsp_in.status = STAT_OK;
               case (req_item.action)
                  ACT_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     clr_in        = '0;
                     state_in      = ST_CLEAR;
                  end
                  ACT_WRITE: begin
                     rsp_strobe_in = 1'b1;
                     if (!a_ok) begin
                        rsp_in.status = STAT_RANGE;
                     end
                  end
                  ACT_TRI: begin
                     if (a_ok && b_ok && c_ok) begin
                        state_in = ST_VRD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_RANGE;
                     end
                  end
                  default: begin
                     if (a_ok) begin
                        state_in = ST_NRM_RD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_RANGE;
                     end
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         // read the three corners, data arrives in the cycle after its address
         ST_VRD: begin
            k_in = k_ff + 3'd1;
            if (k_ff != 3'd0) begin
               p_in[k_ff[1:0] - 2'd1] = vtx_q_ff;
            end
            if (k_ff == 3'd3) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            d_in[0] = 17'(signed'(p_ff[1][15:0]))  - 17'(signed'(p_ff[0][15:0]));
            d_in[1] = 17'(signed'(p_ff[1][31:16])) - 17'(signed'(p_ff[0][31:16]));
            d_in[2] = 17'(signed'(p_ff[1][47:32])) - 17'(signed'(p_ff[0][47:32]));
            d_in[3] = 17'(signed'(p_ff[2][15:0]))  - 17'(signed'(p_ff[0][15:0]));
            d_in[4] = 17'(signed'(p_ff[2][31:16])) - 17'(signed'(p_ff[0][31:16]));
            d_in[5] = 17'(signed'(p_ff[2][47:32])) - 17'(signed'(p_ff[0][47:32]));
            k_in     = 3'd0;
            state_in = ST_CROSS;
         end
         // products arrive in the cycle after their operands
         ST_CROSS: begin
            k_in = k_ff + 3'd1;
            case (k_ff)
               3'd1:    c_in[0] = prod_ff[34:0];
               3'd2:    c_in[0] = c_ff[0] - prod_ff[34:0];
               3'd3:    c_in[1] = prod_ff[34:0];
               3'd4:    c_in[1] = c_ff[1] - prod_ff[34:0];
               3'd5:    c_in[2] = prod_ff[34:0];
               3'd6:    c_in[2] = c_ff[2] - prod_ff[34:0];
               default: c_in[0] = c_ff[0];
            endcase
            if (k_ff == 3'd6) begin
               k_in     = 3'd0;
               state_in = ST_ACC_RD;
            end
         end
         ST_ACC_RD: begin
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd2) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_ACC_RD;
            end
         end
         ST_NRM_RD: begin
            state_in = ST_NRM_LD;
         end
         ST_NRM_LD: begin
            sgn_in = {az[47], ay[47], ax[47]};
            r_in[0] = ax[47] ? -ax : ax;
            r_in[1] = ay[47] ? -ay : ay;
            r_in[2] = az[47] ? -az : az;
            if ((ax == '0) && (ay == '0) && (az == '0)) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = STAT_ZERO;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_NRM_SHIFT;
            end
         end
         // one bit a cycle until every magnitude is below 2^30
         ST_NRM_SHIFT: begin
            if ((r_ff[0][47:30] != '0) || (r_ff[1][47:30] != '0) ||
                (r_ff[2][47:30] != '0)) begin
               r_in[0] = r_ff[0] >> 1;
               r_in[1] = r_ff[1] >> 1;
               r_in[2] = r_ff[2] >> 1;
            end else begin
               k_in     = 3'd0;
               sq_in    = '0;
               state_in = ST_NRM_SQ;
            end
         end
         ST_NRM_SQ: begin
            k_in = k_ff + 3'd1;
            if (k_ff != 3'd0) begin
               sq_in = sq_ff + prod_ff[SQ_W-1:0];
            end
            if (k_ff == 3'd3) begin
               launched_in = 1'b0;
               state_in    = ST_NRM_SQRT;
            end
         end
         ST_NRM_SQRT: begin
            if (!launched_ff) begin
               launched_in = 1'b1;
            end else if (u_stat.done) begin
               launched_in = 1'b0;
               len_in      = (u_root == '0) ? LEN_W'(1) : u_root;
               k_in        = 3'd0;
               state_in    = ST_NRM_DIV;
            end
         end
         ST_NRM_DIV: begin
            if (!launched_ff) begin
               launched_in = 1'b1;
            end else if (u_stat.done) begin
               launched_in         = 1'b0;
               nrm_in[k_ff[1:0]]   = q_signed;
               k_in                = k_ff + 3'd1;
               if (k_ff == 3'd2) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_in.normal_x = nrm_ff[0];
                  rsp_in.normal_y = nrm_ff[1];
                  rsp_in.normal_z = q_signed;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         launched_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         launched_ff   <= launched_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in;
      k_ff   <= k_in;
      p_ff   <= p_in;
      d_ff   <= d_in;
      c_ff   <= c_in;
      r_ff   <= r_in;
      sgn_ff <= sgn_in;
      sq_ff  <= sq_in;
      len_ff <= len_in;
      nrm_ff <= nrm_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR)) else $error("no clearing sweep after reset");
   a_cmd_answered: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy)) else $error("command dropped");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != STAT_OK)) |->
      ((rsp_item.normal_x == '0) && (rsp_item.normal_y == '0) &&
       (rsp_item.normal_z == '0))) else $error("normal on a failed command");
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_item.normal_x <= 16'sd16384) &&
                      (rsp_item.normal_x >= -16'sd16384) &&
                      (rsp_item.normal_y <= 16'sd16384) &&
                      (rsp_item.normal_y >= -16'sd16384) &&
                      (rsp_item.normal_z <= 16'sd16384) &&
                      (rsp_item.normal_z >= -16'sd16384)))
      else $error("normal out of unit range");
`endif

endmodule

// ----- tb/vertex_normal_accumulator_core_tb.sv -----
// testbench of the vertex normal accumulator: predictor, scoreboard and random command stream
`timescale 1ns / 1ps

module vertex_normal_accumulator_core_tb;
   import vna_pkg::*;

   localparam int DEPTH = 1024;
   localparam longint CYCLE_LIMIT = 2000000;

   // scoreboard: predicts each command's answer and checks it against the block
   class normal_scoreboard;
      logic signed [15:0] vx [DEPTH];
      logic signed [15:0] vy [DEPTH];
      logic signed [15:0] vz [DEPTH];
      logic signed [47:0] acc_x [DEPTH];
      logic signed [47:0] acc_y [DEPTH];
      logic signed [47:0] acc_z [DEPTH];
      rsp_type pending [$];
      int errors;

      function void clear_accumulators();
         for (int i = 0; i < DEPTH; i++) begin
            acc_x[i] = '0;
            acc_y[i] = '0;
            acc_z[i] = '0;
         end
      endfunction

      function logic signed [47:0] sat48(logic signed [47:0] a, longint b);
         longint s;
         s = longint'(a) + b;
         if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
         if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
         return s[47:0];
      endfunction

      function longint unsigned root64(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint unsigned magnitude(longint v);
         return v < 0 ? longint'(-v) : longint'(v);
      endfunction

      function logic signed [15:0] unit_part(longint v, int sh, longint unsigned len);
         longint unsigned r, q;
         r = magnitude(v) >> sh;
         q = (r * 32768 + len) / (len * 2);
         if (q > UNIT) q = UNIT;
         if (v < 0) q = -q;
         return q[15:0];
      endfunction

      // note an accepted command and queue its answer
      function void note_command(req_type c);
         rsp_type o;
         longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
         longint unsigned mx, my, mz, m, len;
         int sh;
         int unsigned idx [3];
         o = '{status: STAT_OK, normal_x: 0, normal_y: 0, normal_z: 0};
         case (c.action)
            ACT_CLEAR: clear_accumulators();
            ACT_WRITE: begin
               if (c.index_a >= DEPTH) o.status = STAT_RANGE;
               else begin
                  vx[c.index_a] = c.coord_x;
                  vy[c.index_a] = c.coord_y;
                  vz[c.index_a] = c.coord_z;
               end
            end
            ACT_TRI: begin
               if (c.index_a >= DEPTH || c.index_b >= DEPTH || c.index_c >= DEPTH)
                  o.status = STAT_RANGE;
               else begin
                  ux = vx[c.index_b] - vx[c.index_a];
                  uy = vy[c.index_b] - vy[c.index_a];
                  uz = vz[c.index_b] - vz[c.index_a];
                  wx = vx[c.index_c] - vx[c.index_a];
                  wy = vy[c.index_c] - vy[c.index_a];
                  wz = vz[c.index_c] - vz[c.index_a];
                  cx = uy * wz - uz * wy;
                  cy = uz * wx - ux * wz;
                  cz = ux * wy - uy * wx;
                  idx = '{c.index_a, c.index_b, c.index_c};
                  foreach (idx[k]) begin
                     acc_x[idx[k]] = sat48(acc_x[idx[k]], cx);
                     acc_y[idx[k]] = sat48(acc_y[idx[k]], cy);
                     acc_z[idx[k]] = sat48(acc_z[idx[k]], cz);
                  end
               end
            end
            default: begin
               if (c.index_a >= DEPTH) o.status = STAT_RANGE;
               else begin
                  mx = magnitude(acc_x[c.index_a]);
                  my = magnitude(acc_y[c.index_a]);
                  mz = magnitude(acc_z[c.index_a]);
                  m = mx;
                  if (my > m) m = my;
                  if (mz > m) m = mz;
                  if (m == 0) o.status = STAT_ZERO;
                  else begin
                     sh = 0;
                     while ((m >> sh) >= (64'd1 << 30)) sh++;
                     mx = mx >> sh;
                     my = my >> sh;
                     mz = mz >> sh;
                     len = root64(mx * mx + my * my + mz * mz);
                     if (len == 0) len = 1;
                     o.normal_x = unit_part(acc_x[c.index_a], sh, len);
                     o.normal_y = unit_part(acc_y[c.index_a], sh, len);
                     o.normal_z = unit_part(acc_z[c.index_a], sh, len);
                  end
               end
            end
         endcase
         pending.insert(pending.size(), o);
      endfunction

      // compare one answer with the oldest expectation
      function void check_answer(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected answer, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            $display("%0t: status expected %s actual %s", $time, want.status.name(),
                     got.status.name());
         if (got.normal_x !== want.normal_x)
            $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x,
                     got.normal_x);
         if (got.normal_y !== want.normal_y)
            $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y,
                     got.normal_y);
         if (got.normal_z !== want.normal_z)
            $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z,
                     got.normal_z);
         if (got !== want) errors++;
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_strobe;
   req_type req_item;
   rsp_type rsp_item;
   normal_scoreboard board;
   bit written [DEPTH];
   int unsigned written_list [$];
   int idle_pct;
   longint cycles;

   vertex_normal_accumulator_core #(.MAX_VERTICES(DEPTH)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // transfer monitor: commands and answers at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && start && !busy) board.note_command(req_item);
      if (!reset && rsp_strobe) board.check_answer(rsp_item);
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // send one command, with random idle cycles ahead of it
   // entered and left at a falling edge; busy is stable there
   task automatic send(req_type c);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= c;
      while (busy) @(negedge clock);
      // the next rising edge takes the transfer
      @(negedge clock);
      if (c.action == ACT_WRITE && c.index_a < DEPTH && !written[c.index_a]) begin
         written[c.index_a] = 1'b1;
         written_list.insert(written_list.size(), int'(c.index_a));
      end
   endtask

   function automatic req_type make(action_type a, int unsigned ia, int unsigned ib,
                                    int unsigned ic, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] z);
      req_type c;
      c = '{action: a, index_a: ia, index_b: ib, index_c: ic,
            coord_x: x, coord_y: y, coord_z: z};
      return c;
   endfunction

   // index that is in range and written, mostly small for overlap
   function automatic int unsigned pick_written();
      return written_list[$urandom_range(written_list.size() - 1)];
   endfunction

   function automatic int unsigned any_index();
      case ($urandom_range(9))
         0: return $urandom_range(65535);
         1: return $urandom_range(DEPTH + 3, DEPTH);
         2: return DEPTH - 1;
         default: return $urandom_range(31);
      endcase
   endfunction

   // triangle corner: out of range or a written vertex
   function automatic int unsigned tri_index();
      int unsigned i;
      i = any_index();
      if (i < DEPTH && !written[i]) i = pick_written();
      return i;
   endfunction

   task automatic random_command();
      int unsigned r;
      logic [15:0] x, y, z;
      r = $urandom_range(99);
      x = $urandom;
      y = $urandom;
      z = $urandom;
      if (r < 3) send(make(ACT_CLEAR, $urandom, $urandom, $urandom, x, y, z));
      else if (r < 30) begin
         // mostly small coordinates, sometimes the full range
         if ($urandom_range(3) != 0) begin
            x = $signed(x) >>> 6;
            y = $signed(y) >>> 6;
            z = $signed(z) >>> 6;
         end
         send(make(ACT_WRITE, any_index(), $urandom, $urandom, x, y, z));
      end else if (r < 65) begin
         if ($urandom_range(9) == 0)
            send(make(ACT_TRI, tri_index(), tri_index(), tri_index(), x, y, z));
         else
            send(make(ACT_TRI, pick_written(), pick_written(), pick_written(), x, y, z));
      end else begin
         send(make(ACT_READ, ($urandom_range(7) == 0) ? any_index() : pick_written(),
                   $urandom, $urandom, x, y, z));
      end
   endtask

   initial begin
      board = new();
      board.clear_accumulators();
      cycles = 0;
      idle_pct = 29;
      start = 1'b0;
      req_item = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, all actions and special cases
      send(make(ACT_WRITE, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000));
      send(make(ACT_WRITE, 1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000));
      send(make(ACT_WRITE, 2, 0, 0, 16'h8000, 16'h7FFF, 16'hFFFF));
      send(make(ACT_WRITE, DEPTH - 1, 0, 0, 16'h0100, 16'h0000, 16'h0000));
      send(make(ACT_WRITE, DEPTH, 0, 0, 16'h1234, 16'h5678, 16'h9ABC));
      send(make(ACT_WRITE, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send(make(ACT_READ, 0, 0, 0, 0, 0, 0));                // zero vector
      send(make(ACT_TRI, 0, 1, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send(make(ACT_READ, 0, 0, 0, 0, 0, 0));
      send(make(ACT_TRI, 0, 1, 1, 0, 0, 0));                 // repeated corner
      send(make(ACT_TRI, 0, DEPTH, 1, 0, 0, 0));
      send(make(ACT_TRI, 0, 1, 16'hFFFF, 0, 0, 0));
      send(make(ACT_READ, 16'hFFFF, 0, 0, 0, 0, 0));
      // repeat one triangle to grow the accumulators of 0..2
      repeat (12) send(make(ACT_TRI, 2, 1, 0, 0, 0, 0));
      send(make(ACT_READ, 1, 0, 0, 0, 0, 0));
      send(make(ACT_READ, 2, 0, 0, 0, 0, 0));
      send(make(ACT_TRI, 0, DEPTH - 1, 1, 0, 0, 0));
      send(make(ACT_READ, DEPTH - 1, 0, 0, 0, 0, 0));
      send(make(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send(make(ACT_READ, 1, 0, 0, 0, 0, 0));

      // random: first with idling, then a stretch without, a drain pause and more with idling
      repeat (400) random_command();
      idle_pct = 0;
      repeat (200) random_command();
      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      idle_pct = 29;
      repeat (300) random_command();

      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DEPTH + 200) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
